>>> rtl/core/madu_pkg.sv
// Package for the multiply, accumulate and divide unit.
// Holds the shared constants, command and status types and the divide cost function.
// It depends on nothing else.
package madu_pkg;

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	localparam logic [8:0] MUL_BASE_CYCLES = 9'd44;
	localparam logic [8:0] MUL_MODE_EXTRA = 9'd10;
	localparam logic [8:0] DIV_BASE_CYCLES = 9'd176;
	localparam logic [8:0] DIV_PER_ZERO = 9'd14;
	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

	localparam logic REG_SIGN_MODE = 1'b0;
	localparam logic REG_ACCUMULATE_MODE = 1'b1;

	localparam logic FUNC_MUL = 1'b0;
	localparam logic FUNC_DIV = 1'b1;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic neg_step;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

	// Cost of a divide: a base plus a fixed amount per leading zero of the divisor.
	function automatic logic [8:0] div_cycles(input logic [15:0] dvs);
		logic [4:0] lz;
		logic found;
		lz = 5'd0;
		found = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (dvs[i]) begin
				found = 1'b1;
			end else if (!found) begin
				lz = lz + 5'd1;
			end
		end
		return DIV_BASE_CYCLES + 9'(DIV_PER_ZERO * {4'd0, lz});
	endfunction

endpackage

>>> rtl/core/multiply_accumulate_divide_unit.sv
// Multiply, accumulate and divide unit: top level joining controller and datapath.
// A multiply steps through accept, multiply and negate; a divide through accept and 32 divider steps; both then commit.
// One word is in progress at a time: a new word is accepted only once the previous one has committed.
// A new word is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous) clears the modes, accumulator, math flag, controller state and out_valid.
// Depends on madu_pkg, madu_ctrl and madu_dp.
module multiply_accumulate_divide_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] mul_left,
	input  logic [15:0] mul_right,
	input  logic        left_negative,
	input  logic        right_negative,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] main_result,
	output logic [15:0] remainder,
	output logic [31:0] accumulator_value,
	output logic        carry_flag,
	output logic        math_flag,
	output logic [8:0]  busy_cycles
);

	madu_pkg::cmd_t cmd;
	madu_pkg::status_t status;

	madu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	madu_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.status            (status),
		.func              (func),
		.mul_left          (mul_left),
		.mul_right         (mul_right),
		.left_negative     (left_negative),
		.right_negative    (right_negative),
		.dividend          (dividend),
		.divisor           (divisor),
		.main_result       (main_result),
		.remainder         (remainder),
		.accumulator_value (accumulator_value),
		.carry_flag        (carry_flag),
		.math_flag         (math_flag),
		.busy_cycles       (busy_cycles)
	);

endmodule

>>> rtl/core/madu_ctrl.sv
// Controller state machine of the multiply, accumulate and divide unit.
// Sequences the datapath through commands and owns both handshakes.
// Depends on madu_pkg.
module madu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	output logic               out_valid,
	input  logic               out_ready,
	input  madu_pkg::status_t  status,
	output madu_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_NEG  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = (func == madu_pkg::FUNC_DIV) ? S_DIV : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				state_d = S_NEG;
			end
			S_NEG: begin
				cmd.neg_step = 1'b1;
				state_d = S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/madu_dp.sv
// Datapath of the multiply, accumulate and divide unit.
// Holds the mode registers, multiplier, radix-2 divider, accumulator and result word.
// Depends on madu_pkg.
module madu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic               cfg_data,
	input  madu_pkg::cmd_t     cmd,
	output madu_pkg::status_t  status,
	input  logic               func,
	input  logic [15:0]        mul_left,
	input  logic [15:0]        mul_right,
	input  logic               left_negative,
	input  logic               right_negative,
	input  logic [31:0]        dividend,
	input  logic [15:0]        divisor,
	output logic [31:0]        main_result,
	output logic [15:0]        remainder,
	output logic [31:0]        accumulator_value,
	output logic               carry_flag,
	output logic               math_flag,
	output logic [8:0]         busy_cycles
);

	logic sign_mode_q;
	logic accumulate_mode_q;
	logic [31:0] acc_q;
	logic math_q;

	logic func_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic neg_q;
	logic [15:0] dvs_q;
	logic [31:0] work_q;
	logic [15:0] rem_q;
	logic carry_q;
	logic [madu_pkg::CNT_W-1:0] cnt_q;

	logic [31:0] main_q;
	logic [15:0] rem_out_q;
	logic [31:0] acc_out_q;
	logic carry_out_q;
	logic [8:0] cycles_q;

	logic [16:0] shifted;
	logic [16:0] diff;
	logic [32:0] sum;

	logic [31:0] new_main;
	logic [15:0] new_rem;
	logic [31:0] new_acc;
	logic new_carry;
	logic new_math;
	logic [8:0] new_cycles;

	assign status.div_last = (cnt_q == madu_pkg::CNT_W'(madu_pkg::DIV_STEPS - 1));

	assign shifted = {rem_q, work_q[31]};
	assign diff = shifted - {1'b0, dvs_q};
	assign sum = {1'b0, acc_q} + {1'b0, work_q};

	always_comb begin
		new_main = work_q;
		new_rem = 16'd0;
		new_acc = acc_q;
		new_carry = carry_q;
		new_math = math_q;
		new_cycles = madu_pkg::MUL_BASE_CYCLES;
		if (func_q == madu_pkg::FUNC_MUL) begin
			if (accumulate_mode_q) begin
				new_acc = sum[31:0];
				new_carry = sum[32];
				new_math = sum[32];
			end
			if (sign_mode_q || accumulate_mode_q) begin
				new_cycles = madu_pkg::MUL_BASE_CYCLES + madu_pkg::MUL_MODE_EXTRA;
			end
		end else begin
			new_cycles = madu_pkg::div_cycles(dvs_q);
			if (dvs_q == 16'd0) begin
				new_main = madu_pkg::ALL_ONES32;
				new_carry = 1'b1;
				new_math = 1'b1;
				new_acc = 32'd0;
			end else begin
				new_rem = rem_q;
				new_carry = (rem_q != 16'd0);
				new_math = 1'b0;
				new_acc = {16'd0, rem_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_mode_q <= 1'b0;
			accumulate_mode_q <= 1'b0;
			acc_q <= 32'd0;
			math_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == madu_pkg::REG_SIGN_MODE) begin
				sign_mode_q <= cfg_data;
			end
			if (cfg_write && cfg_index == madu_pkg::REG_ACCUMULATE_MODE) begin
				accumulate_mode_q <= cfg_data;
			end
			if (cmd.commit) begin
				acc_q <= new_acc;
				math_q <= new_math;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			left_q <= mul_left;
			right_q <= mul_right;
			neg_q <= left_negative ^ right_negative;
			dvs_q <= divisor;
			work_q <= dividend;
			rem_q <= 16'd0;
			carry_q <= 1'b0;
			cnt_q <= '0;
		end
		if (cmd.mul_step) begin
			work_q <= {16'd0, left_q} * {16'd0, right_q};
		end
		if (cmd.neg_step && sign_mode_q && neg_q) begin
			work_q <= ~work_q + 32'd1;
			carry_q <= (work_q != 32'd0);
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + madu_pkg::CNT_W'(1);
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				work_q <= {work_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				work_q <= {work_q[30:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			main_q <= new_main;
			rem_out_q <= new_rem;
			acc_out_q <= new_acc;
			carry_out_q <= new_carry;
			cycles_q <= new_cycles;
		end
	end

	// The math flag port follows the live flag, which only changes on commit.
	assign main_result = main_q;
	assign remainder = rem_out_q;
	assign accumulator_value = acc_out_q;
	assign carry_flag = carry_out_q;
	assign math_flag = math_q;
	assign busy_cycles = cycles_q;

endmodule

>>> rtl/core/madu_checker.sv
// Port-level checker for the multiply, accumulate and divide unit.
// Bound to the top level; depends only on its ports.
module madu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] main_result,
	input logic [15:0] remainder,
	input logic        carry_flag,
	input logic        math_flag,
	input logic [8:0]  busy_cycles
);

	// A waiting result word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(main_result))
		else $error("result word changed while stalled");

	// One word at a time: the unit is busy right after it takes a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in progress");

	// A divide by zero reports all-ones, no remainder and both flags.
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_cycles == 9'd400 |->
		carry_flag && math_flag && main_result == 32'hFFFF_FFFF && remainder == 16'd0)
		else $error("divide by zero result malformed");

	// A multiply never reports a remainder.
	a_mul_no_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_cycles < 9'd176 |-> remainder == 16'd0)
		else $error("multiply result carries a remainder");

endmodule

bind multiply_accumulate_divide_unit madu_checker u_madu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.main_result (main_result),
	.remainder   (remainder),
	.carry_flag  (carry_flag),
	.math_flag   (math_flag),
	.busy_cycles (busy_cycles)
);

>>> test/tb_multiply_accumulate_divide_unit.sv
// Testbench for multiply_accumulate_divide_unit: directed and random words under all mode settings.
// A scoreboard class predicts each result from the accepted words and checks every output field.
// Depends on madu_pkg and the RTL of the unit.
module tb_multiply_accumulate_divide_unit;

	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned WORDS_PER_PHASE = 200;

	typedef struct packed {
		logic        func;
		logic [15:0] mul_left;
		logic [15:0] mul_right;
		logic        left_negative;
		logic        right_negative;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} math_op_t;

	typedef struct packed {
		logic [31:0] main_result;
		logic [15:0] remainder;
		logic [31:0] accumulator_value;
		logic        carry_flag;
		logic        math_flag;
		logic [8:0]  busy_cycles;
	} math_outcome_t;

	class math_scoreboard;
		logic          sign_mode;
		logic          accumulate_mode;
		logic [31:0]   acc;
		logic          overflow_flag;
		math_outcome_t awaited[$];
		int unsigned   failures;

		function new();
			sign_mode = 1'b0;
			accumulate_mode = 1'b0;
			acc = '0;
			overflow_flag = 1'b0;
			failures = 0;
		endfunction

		function void set_mode(logic idx, logic val);
			if (idx == madu_pkg::REG_SIGN_MODE) begin
				sign_mode = val;
			end else begin
				accumulate_mode = val;
			end
		endfunction

		function void note_operation(math_op_t op);
			math_outcome_t e;
			logic [31:0] prod;
			logic [32:0] sum;
			logic [15:0] rem;
			int unsigned lz;
			e = '0;
			rem = '0;
			if (op.func == madu_pkg::FUNC_MUL) begin
				prod = 32'(op.mul_left) * 32'(op.mul_right);
				if (sign_mode && (op.left_negative ^ op.right_negative)) begin
					e.carry_flag = (prod != 32'd0);
					prod = ~prod + 32'd1;
				end
				if (accumulate_mode) begin
					sum = {1'b0, acc} + {1'b0, prod};
					e.carry_flag = sum[32];
					overflow_flag = sum[32];
					acc = sum[31:0];
				end
				e.main_result = prod;
				e.busy_cycles = madu_pkg::MUL_BASE_CYCLES +
					((sign_mode || accumulate_mode) ? madu_pkg::MUL_MODE_EXTRA : 9'd0);
			end else begin
				overflow_flag = 1'b0;
				if (op.divisor == 16'd0) begin
					e.main_result = madu_pkg::ALL_ONES32;
					e.carry_flag = 1'b1;
					overflow_flag = 1'b1;
				end else begin
					e.main_result = op.dividend / {16'd0, op.divisor};
					rem = 16'(op.dividend % {16'd0, op.divisor});
					e.carry_flag = (rem != 16'd0);
				end
				acc = {16'd0, rem};
				lz = 0;
				while (lz < 16 && !op.divisor[15 - lz]) begin
					lz++;
				end
				e.busy_cycles = madu_pkg::DIV_BASE_CYCLES + 9'(madu_pkg::DIV_PER_ZERO * lz);
			end
			e.remainder = rem;
			e.accumulator_value = acc;
			e.math_flag = overflow_flag;
			awaited.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_outcome(math_outcome_t got);
			math_outcome_t want;
			if (awaited.size() == 0) begin
				$error("result word with no operation outstanding");
				failures++;
				return;
			end
			want = awaited.pop_front();
			compare_field("main_result", want.main_result, got.main_result);
			compare_field("remainder", 32'(want.remainder), 32'(got.remainder));
			compare_field("accumulator_value", want.accumulator_value,
				got.accumulator_value);
			compare_field("carry_flag", 32'(want.carry_flag), 32'(got.carry_flag));
			compare_field("math_flag", 32'(want.math_flag), 32'(got.math_flag));
			compare_field("busy_cycles", 32'(want.busy_cycles), 32'(got.busy_cycles));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [15:0] mul_left = '0;
	logic [15:0] mul_right = '0;
	logic        left_negative = 1'b0;
	logic        right_negative = 1'b0;
	logic [31:0] dividend = '0;
	logic [15:0] divisor = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] main_result;
	logic [15:0] remainder;
	logic [31:0] accumulator_value;
	logic        carry_flag;
	logic        math_flag;
	logic [8:0]  busy_cycles;

	logic        hold_request = 1'b0;
	logic        fast_mode = 1'b0;
	int unsigned cycle_count = 0;

	math_scoreboard sb = new();

	multiply_accumulate_divide_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.mul_left(mul_left),
		.mul_right(mul_right),
		.left_negative(left_negative),
		.right_negative(right_negative),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.main_result(main_result),
		.remainder(remainder),
		.accumulator_value(accumulator_value),
		.carry_flag(carry_flag),
		.math_flag(math_flag),
		.busy_cycles(busy_cycles)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// The receiver owns out_ready; a long hold-off is counted here once requested.
	initial begin
		int unsigned stall_left;
		int unsigned pick;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_outcome({main_result, remainder, accumulator_value,
					carry_flag, math_flag, busy_cycles});
			end
			if (hold_request) begin
				hold_request <= 1'b0;
				stall_left = 300;
			end
			pick = $urandom_range(0, 99);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (fast_mode || pick < 60) begin
				out_ready <= 1'b1;
			end else if (pick < 92) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				stall_left = $urandom_range(10, 40);
				out_ready <= 1'b0;
			end
		end
	end

	function automatic logic [15:0] any16();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic math_op_t random_op();
		math_op_t op;
		op.func = $urandom_range(0, 1) ? madu_pkg::FUNC_DIV : madu_pkg::FUNC_MUL;
		op.mul_left = any16();
		op.mul_right = any16();
		op.left_negative = 1'($urandom);
		op.right_negative = 1'($urandom);
		case ($urandom_range(0, 5))
			0: op.dividend = madu_pkg::ALL_ONES32;
			1, 2: op.dividend = $urandom >> $urandom_range(0, 31);
			default: op.dividend = $urandom;
		endcase
		op.divisor = 16'($urandom) & (16'hFFFF >> $urandom_range(0, 16));
		return op;
	endfunction

	function automatic math_op_t make_op(logic f, logic [15:0] a, logic [15:0] b,
			logic ln, logic rn, logic [31:0] dvd, logic [15:0] dvs);
		return '{f, a, b, ln, rn, dvd, dvs};
	endfunction

	task automatic send_op(input math_op_t op);
		in_valid <= 1'b1;
		func <= op.func;
		mul_left <= op.mul_left;
		mul_right <= op.mul_right;
		left_negative <= op.left_negative;
		right_negative <= op.right_negative;
		dividend <= op.dividend;
		divisor <= op.divisor;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sb.note_operation(op);
	endtask

	task automatic pause_sender();
		int unsigned gap;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (fast_mode || pick < 50) begin
			gap = 0;
		end else if (pick < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_modes(input logic sign_val, input logic acc_val);
		cfg_write <= 1'b1;
		cfg_index <= madu_pkg::REG_SIGN_MODE;
		cfg_data <= sign_val;
		@(posedge clk);
		cfg_index <= madu_pkg::REG_ACCUMULATE_MODE;
		cfg_data <= acc_val;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_mode(madu_pkg::REG_SIGN_MODE, sign_val);
		sb.set_mode(madu_pkg::REG_ACCUMULATE_MODE, acc_val);
	endtask

	initial begin
		logic sign_val;
		logic acc_val;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain products and divides, including a zero divisor and a divisor with its top bit set.
		set_modes(1'b0, 1'b0);
		send_op(make_op(madu_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'h0000, 16'hFFFF, 1'b0, 1'b1, '0, '0));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'd1));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'h89AB_CDEF, 16'd0));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'h1234_5678, 16'h8000));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'd0, 16'd7));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
		drain();

		// Sign mode alone: negation, same signs, and a zero product with differing signs.
		set_modes(1'b1, 1'b0);
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd3, 16'd5, 1'b1, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd3, 16'd5, 1'b1, 1'b1, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd0, 16'd9, 1'b0, 1'b1, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, '0, '0));
		drain();

		// Accumulate alone: overflow of the sum, clearing of the flag, divide by zero in between.
		set_modes(1'b0, 1'b1);
		send_op(make_op(madu_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd1, 16'd1, 1'b0, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'd100, 16'd0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd2, 16'd3, 1'b0, 1'b0, '0, '0));
		drain();

		// Both modes: negated and plain products added into the accumulator, then a divide.
		set_modes(1'b1, 1'b1);
		send_op(make_op(madu_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd0, 16'd5, 1'b1, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd7, 16'd7, 1'b1, 1'b0, '0, '0));
		send_op(make_op(madu_pkg::FUNC_MUL, 16'd1, 16'd1, 1'b1, 1'b1, '0, '0));
		send_op(make_op(madu_pkg::FUNC_DIV, '0, '0, 1'b0, 1'b0, 32'd7, 16'd3));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph < 4) begin
				sign_val = ph[0];
				acc_val = ph[1];
			end else begin
				sign_val = 1'($urandom);
				acc_val = 1'($urandom);
			end
			set_modes(sign_val, acc_val);
			fast_mode <= (ph == 2 || ph == 5);
			if (ph == 2) begin
				hold_request <= 1'b1;
			end
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				send_op(random_op());
				if ($urandom_range(0, 149) == 0) begin
					drain();
				end else begin
					pause_sender();
				end
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.failures == 0 && sb.awaited.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/madu_pkg.sv
rtl/core/madu_ctrl.sv
rtl/core/madu_dp.sv
rtl/core/multiply_accumulate_divide_unit.sv
rtl/core/madu_checker.sv
test/tb_multiply_accumulate_divide_unit.sv
